// ----- rtl/rc4_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants and types for the rc4 stream cipher block.
// ----------------------------------------------------------------------------
package rc4_pkg;

	localparam int KEY_BYTES_MAX = 16;
	localparam int KEY_LEN_W     = 5;
	localparam int KIDX_W        = 4;
	localparam int KEY_W         = 128;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_LOW  = 2'd0,
		REG_KEY_HIGH = 2'd1,
		REG_KEY_LEN  = 2'd2
	} cfg_reg_t;

	// engine status towards the output buffer
	typedef struct packed {
		logic       free;
		logic       res_valid;
		logic [7:0] res_byte;
	} rc4_stat_t;

endpackage

// ----- rtl/rc4_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_engine
// Permutation memory with key schedule and keystream sequencer.
// ----------------------------------------------------------------------------
module rc4_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [7:0]                    data_byte,
	input  logic                          last_byte,
	input  logic [rc4_pkg::KEY_W-1:0]     key,
	input  logic [rc4_pkg::KEY_LEN_W-1:0] key_length,
	output rc4_pkg::rc4_stat_t            stat
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_FILL = 10'b0000000010,
		ST_K_RN = 10'b0000000100,
		ST_K_RJ = 10'b0000001000,
		ST_K_WN = 10'b0000010000,
		ST_K_WJ = 10'b0000100000,
		ST_G1   = 10'b0001000000,
		ST_G2   = 10'b0010000000,
		ST_G3   = 10'b0100000000,
		ST_G4   = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [7:0] sbox_mem [256];
	logic [7:0] mem_rdata_q;
	logic [7:0] mem_raddr;
	logic [7:0] mem_waddr;
	logic [7:0] mem_wdata;
	logic       mem_we;

	logic [7:0] i_q;
	logic [7:0] j_q;
	logic [7:0] n_q;
	logic [7:0] si_q;
	logic [7:0] sj_q;
	logic [7:0] t_q;
	logic [7:0] data_q;
	logic       last_q;
	logic       keyed_q;
	logic       fwd_q;
	logic [rc4_pkg::KIDX_W-1:0] kidx_q;

	logic [rc4_pkg::KEY_LEN_W-1:0] len_eff;
	logic [rc4_pkg::KIDX_W-1:0]    kidx_last;
	logic [7:0]                    key_sel;
	logic [7:0]                    i_inc;
	logic [7:0]                    si_g2;
	logic [7:0]                    j_g2;
	logic [7:0]                    j_ksa;
	logic [7:0]                    t_g3;
	logic [7:0]                    ks;
	logic                          keyed_nxt;

	// clamp key length to one .. KEY_BYTES_MAX
	always_comb begin
		if (key_length == '0) begin
			len_eff = rc4_pkg::KEY_LEN_W'(1);
		end else if (key_length > rc4_pkg::KEY_LEN_W'(rc4_pkg::KEY_BYTES_MAX)) begin
			len_eff = rc4_pkg::KEY_LEN_W'(rc4_pkg::KEY_BYTES_MAX);
		end else begin
			len_eff = key_length;
		end
	end

	assign kidx_last = rc4_pkg::KIDX_W'(len_eff - rc4_pkg::KEY_LEN_W'(1));
	assign key_sel   = key[kidx_q*8 +: 8];
	assign i_inc     = 8'(i_q + 8'd1);
	assign si_g2     = fwd_q ? si_q : mem_rdata_q;
	assign j_g2      = 8'(j_q + si_g2);
	assign j_ksa     = 8'(j_q + mem_rdata_q + key_sel);
	assign t_g3      = 8'(si_q + mem_rdata_q);
	assign keyed_nxt = keyed_q && !last_q;

	// the write of S[i] lands on the same edge as the read of S[t]
	always_comb begin
		if (t_q == j_q) begin
			ks = si_q;
		end else if (t_q == i_q) begin
			ks = sj_q;
		end else begin
			ks = mem_rdata_q;
		end
	end

	always_comb begin
		mem_raddr = i_inc;
		mem_waddr = n_q;
		mem_wdata = n_q;
		mem_we    = 1'b0;
		case (state_q)
			ST_FILL: begin
				mem_we = 1'b1;
			end
			ST_K_RN: begin
				mem_raddr = n_q;
			end
			ST_K_RJ: begin
				mem_raddr = j_ksa;
			end
			ST_K_WN: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata_q;
			end
			ST_K_WJ: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = si_q;
			end
			ST_G2: begin
				mem_raddr = j_g2;
			end
			ST_G3: begin
				mem_raddr = t_g3;
				mem_we    = 1'b1;
				mem_waddr = i_q;
				mem_wdata = mem_rdata_q;
			end
			ST_G4: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = si_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sbox_mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= sbox_mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			data_q <= data_byte;
			last_q <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			n_q     <= '0;
			si_q    <= '0;
			sj_q    <= '0;
			t_q     <= '0;
			keyed_q <= 1'b0;
			fwd_q   <= 1'b0;
			kidx_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (keyed_q) begin
							i_q     <= i_inc;
							fwd_q   <= 1'b0;
							state_q <= ST_G2;
						end else begin
							n_q     <= '0;
							state_q <= ST_FILL;
						end
					end
				end
				ST_FILL: begin
					n_q <= 8'(n_q + 8'd1);
					if (n_q == 8'hFF) begin
						j_q     <= '0;
						kidx_q  <= '0;
						state_q <= ST_K_RN;
					end
				end
				ST_K_RN: begin
					state_q <= ST_K_RJ;
				end
				ST_K_RJ: begin
					si_q    <= mem_rdata_q;
					j_q     <= j_ksa;
					state_q <= ST_K_WN;
				end
				ST_K_WN: begin
					state_q <= ST_K_WJ;
				end
				ST_K_WJ: begin
					n_q    <= 8'(n_q + 8'd1);
					kidx_q <= (kidx_q == kidx_last) ? '0
						: rc4_pkg::KIDX_W'(kidx_q + rc4_pkg::KIDX_W'(1));
					if (n_q == 8'hFF) begin
						i_q     <= '0;
						j_q     <= '0;
						keyed_q <= 1'b1;
						state_q <= ST_G1;
					end else begin
						state_q <= ST_K_RN;
					end
				end
				ST_G1: begin
					i_q     <= i_inc;
					fwd_q   <= 1'b0;
					state_q <= ST_G2;
				end
				ST_G2: begin
					si_q    <= si_g2;
					j_q     <= j_g2;
					state_q <= ST_G3;
				end
				ST_G3: begin
					t_q     <= t_g3;
					sj_q    <= mem_rdata_q;
					state_q <= ST_G4;
				end
				ST_G4: begin
					keyed_q <= keyed_nxt;
					if (start) begin
						if (keyed_nxt) begin
							// next read of S[i] overlaps the write of S[j]
							i_q     <= i_inc;
							fwd_q   <= (i_inc == j_q);
							state_q <= ST_G2;
						end else begin
							n_q     <= '0;
							state_q <= ST_FILL;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat.free      = (state_q == ST_IDLE) || (state_q == ST_G4);
	assign stat.res_valid = (state_q == ST_G4);
	assign stat.res_byte  = data_q ^ ks;

endmodule

// ----- rtl/rc4_stream_cipher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 stream cipher: keyed from configuration registers, one byte per transfer.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------
//  input    | in_valid / in_ready   | data_byte[7:0], last_byte
//  output   | out_valid / out_ready | out_byte[7:0]
//  config   | cfg_we                | cfg_index[1:0], cfg_data[63:0]
//
//  a keyed byte runs from input transfer through states G2, G3 and G4, where its
//  result is valid, following the read, read, write/read, write sequence on the
//  permutation memory, which has one read and one write port. a new byte can be
//  taken in G4 while the two-entry output buffer has room. rekey (after reset or
//  a byte marked last) adds 256 fill writes, 256 schedule steps of K_RN, K_RJ,
//  K_WN and K_WJ, and the restart state G1. reset clears control state only; the
//  permutation memory is never cleared.
module rc4_stream_cipher (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           last_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     out_byte,
	input  logic                           cfg_we,
	input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [63:0]                   key_low_q;
	logic [63:0]                   key_high_q;
	logic [rc4_pkg::KEY_LEN_W-1:0] key_len_q;

	rc4_pkg::rc4_stat_t eng_stat;

	logic [7:0] buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic [1:0] cnt_nxt;
	logic       take;
	logic       start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			key_len_q  <= rc4_pkg::KEY_LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				rc4_pkg::REG_KEY_LOW: begin
					key_low_q <= cfg_data;
				end
				rc4_pkg::REG_KEY_HIGH: begin
					key_high_q <= cfg_data;
				end
				rc4_pkg::REG_KEY_LEN: begin
					key_len_q <= cfg_data[rc4_pkg::KEY_LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign take    = out_valid && out_ready;
	assign cnt_nxt = 2'(cnt_q + {1'b0, eng_stat.res_valid} - {1'b0, take});
	// a new byte needs a free buffer slot by the time its result lands
	assign in_ready = eng_stat.free && (cnt_nxt != 2'd2);
	assign start    = in_valid && in_ready;

	rc4_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.key        ({key_high_q, key_low_q}),
		.key_length (key_len_q),
		.stat       (eng_stat)
	);

	always_ff @(posedge clk) begin
		if (eng_stat.res_valid) begin
			buf_q[wr_ptr_q] <= eng_stat.res_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (eng_stat.res_valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_nxt;
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign out_byte  = buf_q[rd_ptr_q];

	// a result never lands in a full buffer
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		eng_stat.res_valid |-> (cnt_q != 2'd2) || take)
		else $error("result written into full output buffer");

	// after a transfer in, the engine is busy for at least the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !eng_stat.res_valid && !eng_stat.free)
		else $error("engine idle right after input transfer");

	// a transfer in only happens when the buffer will not be full afterwards
	a_room_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (cnt_q != 2'd2) || $past(cnt_nxt) != 2'd2)
		else $error("input taken without output buffer room");

endmodule

// ----- sim/rc4_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_checker
// Watches the rc4 input, output and register write ports, keeps its own copy
// of the cipher state and key, predicts each output byte and compares it with
// the byte seen on every output transfer.
// ----------------------------------------------------------------------------
module rc4_checker
	import rc4_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [7:0]            out_byte,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           fail_count,
	output int unsigned           pending,
	output int unsigned           bytes_checked,
	output int unsigned           schedules
);

	logic [7:0]           sbox [256];
	logic [7:0]           idx_i;
	logic [7:0]           idx_j;
	logic                 keyed;
	logic [63:0]          key_lo;
	logic [63:0]          key_hi;
	logic [KEY_LEN_W-1:0] key_len;
	logic [7:0]           expected_bytes [$];
	int unsigned          errors = 0;
	int unsigned          checked = 0;
	int unsigned          sched_runs = 0;

	function automatic logic [7:0] key_byte_at(int unsigned k);
		logic [63:0] word;
		word = (k < 8) ? key_lo : key_hi;
		return word[(k % 8) * 8 +: 8];
	endfunction

	function automatic void key_schedule();
		int unsigned len;
		logic [7:0]  j;
		logic [7:0]  t;
		len = key_len;
		// zero length acts as one byte, long keys clip to the maximum
		if (len == 0)
			len = 1;
		if (len > KEY_BYTES_MAX)
			len = KEY_BYTES_MAX;
		for (int n = 0; n < 256; n++)
			sbox[n] = 8'(n);
		j = 8'd0;
		for (int n = 0; n < 256; n++) begin
			j = j + sbox[n] + key_byte_at(n % len);
			t = sbox[n];
			sbox[n] = sbox[j];
			sbox[j] = t;
		end
		idx_i = 8'd0;
		idx_j = 8'd0;
		keyed = 1'b1;
	endfunction

	function automatic logic [7:0] cipher_byte(logic [7:0] d);
		logic [7:0] t;
		logic [7:0] k;
		idx_i = idx_i + 8'd1;
		idx_j = idx_j + sbox[idx_i];
		t = sbox[idx_i];
		sbox[idx_i] = sbox[idx_j];
		sbox[idx_j] = t;
		k = sbox[idx_i] + sbox[idx_j];
		return d ^ sbox[k];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] want;
		if (!arst_n) begin
			key_lo = '0;
			key_hi = '0;
			key_len = KEY_LEN_W'(1);
			idx_i = '0;
			idx_j = '0;
			keyed = 1'b0;
			expected_bytes.delete();
		end else begin
			// queue first so that a same-edge output still pops the oldest byte
			if (in_valid && in_ready) begin
				if (!keyed) begin
					key_schedule();
					sched_runs++;
				end
				expected_bytes.push_back(cipher_byte(data_byte));
				if (last_byte)
					keyed = 1'b0;
			end
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					errors++;
					if (errors <= 20)
						$display("%0t: out_byte transfer with nothing expected, expected none actual %02h",
							$time, out_byte);
				end else begin
					want = expected_bytes.pop_front();
					checked++;
					if (out_byte !== want) begin
						errors++;
						if (errors <= 20)
							$display("%0t: out_byte mismatch, expected %02h actual %02h",
								$time, want, out_byte);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_LOW:  key_lo = cfg_data;
					REG_KEY_HIGH: key_hi = cfg_data;
					REG_KEY_LEN:  key_len = cfg_data[KEY_LEN_W-1:0];
					default: ;
				endcase
			end
		end
		fail_count    <= errors;
		pending       <= expected_bytes.size();
		bytes_checked <= checked;
		schedules     <= sched_runs;
	end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the rc4 stream cipher with directed key corner cases and random
// messages under random source gaps and sink stalls; the checker alongside
// predicts and compares every output byte.
// ----------------------------------------------------------------------------
module testbench;
	import rc4_pkg::*;

	localparam int unsigned          CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned          RANDOM_ITEMS = 1150;
	localparam int unsigned          MAX_IDLE     = 17;
	localparam int unsigned          LONG_HOLD    = 400;
	localparam int unsigned          END_SETTLE   = 20;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            data_byte = '0;
	logic                  last_byte = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            out_byte;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned bytes_checked;
	int unsigned schedules;
	int unsigned cycle_count = 0;
	int unsigned reg_writes = 0;
	int unsigned random_sent = 0;
	logic        steady = 1'b0;
	logic        sink_hold_req = 1'b0;

	rc4_stream_cipher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rc4_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.bytes_checked (bytes_checked),
		.schedules     (schedules)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// valid stays up across back-to-back bytes; only dropped before a gap
	task automatic send_byte(input logic [7:0] d, input logic l);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
	endtask

	// sink side: random stalls between transfers, one long hold on request
	initial begin : sink
		int unsigned hold;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (sink_hold_req) begin
				hold = LONG_HOLD;
				sink_hold_req = 1'b0;
			end else begin
				hold = steady ? 0 : $urandom_range(0, MAX_IDLE);
			end
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int unsigned          phase;
		int unsigned          budget;
		int unsigned          msg_len;
		logic [KEY_LEN_W-1:0] len;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset key: one zero byte
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h5A, 1'b1);

		// zero length with junk above the length field
		drain();
		write_reg(REG_KEY_LEN, 64'hFFFF_FFFF_FFFF_FFE0);
		write_reg(REG_KEY_LOW, '1);
		write_reg(REG_KEY_HIGH, '0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);

		// length above the maximum clips to sixteen bytes
		drain();
		write_reg(REG_KEY_LEN, 64'd31);
		write_reg(REG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
		write_reg(REG_KEY_HIGH, '1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b1);

		drain();
		write_reg(REG_KEY_LEN, 64'(KEY_BYTES_MAX));
		write_reg(REG_KEY_LOW, '0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hFE, 1'b1);

		// unmapped index must leave the key alone
		drain();
		write_reg(REG_UNUSED, rand64());
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b1);

		// key change inside a message only applies after its last byte
		drain();
		write_reg(REG_KEY_LEN, 64'd1);
		write_reg(REG_KEY_LOW, 64'h80);
		send_byte(8'h3C, 1'b0);
		drain();
		write_reg(REG_KEY_LOW, rand64());
		write_reg(REG_KEY_LEN, 64'd5);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h0F, 1'b1);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h99, 1'b1);

		drain();
		write_reg(REG_KEY_LEN, 64'(KEY_BYTES_MAX + 1));
		send_byte(8'h12, 1'b1);
		// single-byte messages, a fresh schedule each
		send_byte(8'h34, 1'b1);
		send_byte(8'h56, 1'b1);
		send_byte(8'h78, 1'b1);

		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			drain();
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_KEY_LOW, rand64());
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_KEY_HIGH, rand64());
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 9))
					0:       len = '0;
					1:       len = KEY_LEN_W'($urandom_range(KEY_BYTES_MAX + 1, 31));
					2:       len = KEY_LEN_W'(KEY_BYTES_MAX);
					3:       len = KEY_LEN_W'(1);
					default: len = KEY_LEN_W'($urandom_range(1, KEY_BYTES_MAX));
				endcase
				write_reg(REG_KEY_LEN, (rand64() & ~64'h1F) | 64'(len));
			end
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_UNUSED, rand64());
			steady = (phase % 4 == 1);
			// sink holds off while the source keeps offering, so the block backs up
			if (phase == 2) begin
				steady = 1'b1;
				sink_hold_req = 1'b1;
			end
			budget = $urandom_range(60, 140);
			while (budget != 0) begin
				msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
				                                      : $urandom_range(1, 20);
				// a phase may end inside a message, leaving the next key for later
				for (int k = 0; k < msg_len && budget != 0; k++) begin
					send_byte(8'($urandom), k == msg_len - 1 || $urandom_range(0, 31) == 0);
					budget--;
					random_sent++;
					if ($urandom_range(0, 59) == 0)
						drain();
				end
			end
			phase++;
		end

		drain();
		repeat (END_SETTLE) @(posedge clk);
		$display("run covered %0d random bytes in %0d phases after the key corner cases",
			random_sent, phase);
		$display("%0d bytes compared, %0d key schedules, %0d register writes",
			bytes_checked, schedules, reg_writes);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
